// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcm_pkg
// Types, constants and helpers shared by the chain manager modules.
// ----------------------------------------------------------------------------
package fcm_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int N_W         = $clog2(TABLE_DEPTH + 1);
  localparam int BLK_W       = 16;
  localparam int OFS_W       = 28;
  localparam int CNT_W       = 13;
  localparam int CODE_W      = 3;
  localparam int CFG_W       = 13;
  localparam int BASE_SHIFT  = 8;

  localparam logic [BLK_W-1:0]  END_MARK   = 16'hFFFF;
  localparam logic [BLK_W-1:0]  FREE_MARK  = 16'h0000;
  localparam logic [CODE_W-1:0] MAX_CODE   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_RESET = 3'd4;
  localparam logic [CFG_W-1:0]  COUNT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_TAIL,
    KIND_FREE,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_RANGE,
    ST_LONG
  } status_t;

  typedef enum logic {
    CFG_BLOCK_SIZE,
    CFG_ENTRY_COUNT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SCAN,
    S_LINK,
    S_WALK,
    S_FREE,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [BLK_W-1:0] block;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_index;
    logic [OFS_W-1:0] data_offset;
    logic [CNT_W-1:0] freed_count;
    status_t          status;
  } rsp_t;

  // Finished request handed from the controller to the output stage.
  typedef struct packed {
    logic [BLK_W-1:0] block_index;
    logic [CNT_W-1:0] freed_count;
    status_t          status;
  } fin_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [BLK_W-1:0] data;
  } ram_wr_t;

  // Number of entries in use, held to 2 .. TABLE_DEPTH.
  function automatic logic [N_W-1:0] eff_count(input logic [CFG_W-1:0] cnt);
    logic [31:0] c;
    c = 32'(cnt);
    if (c > 32'(TABLE_DEPTH)) begin
      c = 32'(TABLE_DEPTH);
    end else if (c < 32'd2) begin
      c = 32'd2;
    end
    return N_W'(c);
  endfunction

endpackage

// ===== sv/fcm_table_ram.sv =====
// ----------------------------------------------------------------------------
// fcm_table_ram
// Allocation table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fcm_table_ram (
  input  logic                                clk,
  input  fcm_pkg::ram_wr_t                    wr,
  input  logic [fcm_pkg::IDX_W-1:0]           rd_addr,
  output logic [fcm_pkg::BLK_W-1:0]           rd_data
);

  logic [fcm_pkg::BLK_W-1:0] mem [fcm_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/fcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcm_ctrl
// Request sequencer: clearing pass, free-entry scan, chain walks and frees.
// ----------------------------------------------------------------------------
module fcm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fcm_pkg::N_W-1:0]       n,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  fcm_pkg::req_t                 req,
  output logic [fcm_pkg::IDX_W-1:0]     rd_addr,
  input  logic [fcm_pkg::BLK_W-1:0]     rd_data,
  output fcm_pkg::ram_wr_t              wr,
  output fcm_pkg::fin_t                 fin,
  output logic                          fin_load,
  input  logic                          res_busy
);

  fcm_pkg::state_t                 state;
  fcm_pkg::state_t                 state_next;
  logic [fcm_pkg::IDX_W-1:0]       clr_addr;
  fcm_pkg::kind_t                  kind;
  logic [fcm_pkg::BLK_W-1:0]       blk;
  logic [fcm_pkg::IDX_W-1:0]       cur;
  logic [fcm_pkg::CNT_W-1:0]       visited;
  logic [fcm_pkg::N_W-1:0]         scan_addr;
  logic                            chk_valid;
  logic [fcm_pkg::IDX_W-1:0]       chk_addr;
  logic [fcm_pkg::IDX_W-1:0]       alloc_idx;

  logic blk_zero;
  logic blk_over;
  logic link_end;
  logic link_bad;
  logic walk_long;
  logic scan_more;
  logic scan_hit;
  logic clr_last;

  assign blk_zero  = (blk == fcm_pkg::FREE_MARK);
  assign blk_over  = (32'(blk) >= 32'(n));
  assign link_end  = (rd_data == fcm_pkg::END_MARK);
  assign link_bad  = (rd_data == fcm_pkg::FREE_MARK) || (32'(rd_data) >= 32'(n));
  assign walk_long = (32'(visited) >= (32'(n) - 32'd1));
  assign scan_more = (32'(scan_addr) < 32'(n));
  assign scan_hit  = chk_valid && (rd_data == fcm_pkg::FREE_MARK);
  assign clr_last  = (clr_addr == fcm_pkg::IDX_W'(fcm_pkg::TABLE_DEPTH - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      fcm_pkg::S_CLEAR: begin
        if (clr_last) state_next = fcm_pkg::S_IDLE;
      end
      fcm_pkg::S_IDLE: begin
        if (req_valid) state_next = fcm_pkg::S_START;
      end
      fcm_pkg::S_START: begin
        unique case (kind)
          fcm_pkg::KIND_ALLOC: begin
            state_next = (!blk_zero && blk_over) ? fcm_pkg::S_FINISH : fcm_pkg::S_SCAN;
          end
          fcm_pkg::KIND_READ: begin
            state_next = (blk_zero || blk_over) ? fcm_pkg::S_FINISH : fcm_pkg::S_READ;
          end
          fcm_pkg::KIND_TAIL, fcm_pkg::KIND_FREE: begin
            state_next = (blk_zero || blk_over) ? fcm_pkg::S_FINISH : fcm_pkg::S_WALK;
          end
          default: state_next = fcm_pkg::S_FINISH;
        endcase
      end
      fcm_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_next = blk_zero ? fcm_pkg::S_FINISH : fcm_pkg::S_LINK;
        end else if (!scan_more && !chk_valid) begin
          state_next = fcm_pkg::S_FINISH;
        end
      end
      fcm_pkg::S_LINK: state_next = fcm_pkg::S_FINISH;
      fcm_pkg::S_WALK: begin
        if (link_end) begin
          state_next = (kind == fcm_pkg::KIND_FREE) ? fcm_pkg::S_FREE : fcm_pkg::S_FINISH;
        end else if (link_bad || walk_long) begin
          state_next = fcm_pkg::S_FINISH;
        end
      end
      fcm_pkg::S_FREE: begin
        if (link_end) state_next = fcm_pkg::S_FINISH;
      end
      fcm_pkg::S_READ: state_next = fcm_pkg::S_FINISH;
      fcm_pkg::S_FINISH: begin
        if (!res_busy) state_next = fcm_pkg::S_IDLE;
      end
      default: state_next = fcm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != fcm_pkg::S_IDLE);
    fin_load  = (state == fcm_pkg::S_FINISH) && !res_busy;
    rd_addr   = cur;
    wr        = '0;
    unique case (state)
      fcm_pkg::S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_addr;
        wr.data = (clr_addr == fcm_pkg::IDX_W'(1)) ? fcm_pkg::END_MARK : fcm_pkg::FREE_MARK;
      end
      fcm_pkg::S_START: rd_addr = blk[fcm_pkg::IDX_W-1:0];
      fcm_pkg::S_SCAN: begin
        rd_addr = scan_addr[fcm_pkg::IDX_W-1:0];
        if (scan_hit) begin
          wr.en   = 1'b1;
          wr.addr = chk_addr;
          wr.data = fcm_pkg::END_MARK;
        end
      end
      fcm_pkg::S_LINK: begin
        wr.en   = 1'b1;
        wr.addr = blk[fcm_pkg::IDX_W-1:0];
        wr.data = fcm_pkg::BLK_W'(alloc_idx);
      end
      fcm_pkg::S_WALK: begin
        // At the tail the free pass restarts from the head of the chain.
        rd_addr = link_end ? blk[fcm_pkg::IDX_W-1:0] : rd_data[fcm_pkg::IDX_W-1:0];
      end
      fcm_pkg::S_FREE: begin
        // The chain was checked, so the next entry is never the one cleared here.
        wr.en   = 1'b1;
        wr.addr = cur;
        wr.data = fcm_pkg::FREE_MARK;
        rd_addr = rd_data[fcm_pkg::IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fcm_pkg::S_CLEAR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        fcm_pkg::S_CLEAR: clr_addr <= clr_addr + fcm_pkg::IDX_W'(1);
        fcm_pkg::S_IDLE: begin
          if (req_valid) begin
            kind <= req.kind;
            blk  <= req.block;
          end
        end
        fcm_pkg::S_START: begin
          cur             <= blk[fcm_pkg::IDX_W-1:0];
          visited         <= fcm_pkg::CNT_W'(1);
          scan_addr       <= fcm_pkg::N_W'(1);
          chk_valid       <= 1'b0;
          fin.block_index <= '0;
          fin.freed_count <= '0;
          fin.status      <= fcm_pkg::ST_OK;
          if (kind == fcm_pkg::KIND_ALLOC) begin
            if (!blk_zero && blk_over) fin.status <= fcm_pkg::ST_RANGE;
          end else if (blk_zero || blk_over) begin
            fin.status <= fcm_pkg::ST_RANGE;
          end
        end
        fcm_pkg::S_SCAN: begin
          if (scan_hit) begin
            alloc_idx       <= chk_addr;
            fin.block_index <= fcm_pkg::BLK_W'(chk_addr);
          end else if (scan_more) begin
            chk_valid <= 1'b1;
            chk_addr  <= scan_addr[fcm_pkg::IDX_W-1:0];
            scan_addr <= scan_addr + fcm_pkg::N_W'(1);
          end else begin
            chk_valid <= 1'b0;
            if (!chk_valid) fin.status <= fcm_pkg::ST_FULL;
          end
        end
        fcm_pkg::S_WALK: begin
          if (link_end) begin
            fin.block_index <= fcm_pkg::BLK_W'(cur);
            if (kind == fcm_pkg::KIND_FREE) fin.freed_count <= visited;
            cur <= blk[fcm_pkg::IDX_W-1:0];
          end else if (link_bad) begin
            fin.status <= fcm_pkg::ST_RANGE;
          end else if (walk_long) begin
            fin.status <= fcm_pkg::ST_LONG;
          end else begin
            cur     <= rd_data[fcm_pkg::IDX_W-1:0];
            visited <= visited + fcm_pkg::CNT_W'(1);
          end
        end
        fcm_pkg::S_FREE: cur <= rd_data[fcm_pkg::IDX_W-1:0];
        fcm_pkg::S_READ: fin.block_index <= rd_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/fcm_result.sv =====
// ----------------------------------------------------------------------------
// fcm_result
// Output register: adds the data offset and holds the result until taken.
// ----------------------------------------------------------------------------
module fcm_result (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fcm_pkg::N_W-1:0]        n,
  input  logic [fcm_pkg::CODE_W-1:0]     block_size_code,
  input  fcm_pkg::fin_t                  fin,
  input  logic                           fin_load,
  output logic                           res_busy,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output fcm_pkg::rsp_t                  rsp
);

  logic [fcm_pkg::CODE_W-1:0] code_c;
  logic [3:0]                 shamt;
  logic                       in_range;
  logic [fcm_pkg::OFS_W-1:0]  offset;

  assign res_busy = rsp_valid && rsp_stall;
  assign code_c   = (block_size_code > fcm_pkg::MAX_CODE) ? fcm_pkg::MAX_CODE : block_size_code;
  assign shamt    = 4'(fcm_pkg::BASE_SHIFT) + 4'(code_c);
  assign in_range = (fin.status == fcm_pkg::ST_OK) && (fin.block_index != '0) &&
                    (32'(fin.block_index) < 32'(n));
  assign offset   = in_range ?
                    (fcm_pkg::OFS_W'(fin.block_index - fcm_pkg::BLK_W'(1)) << shamt) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      rsp.block_index <= fin.block_index;
      rsp.data_offset <= offset;
      rsp.freed_count <= fin.freed_count;
      rsp.status      <= fin.status;
    end
  end

endmodule

// ===== sv/fat_chain_manager.sv =====
// ----------------------------------------------------------------------------
// fat_chain_manager
// Allocation table of block chains: allocate, find tail, free, read link.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  req      | req_valid / req_stall | req: kind, block
//  rsp      | rsp_valid / rsp_stall | rsp: block_index, data_offset,
//           |                       |      freed_count, status
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request is worked at a time, one table entry per cycle through the
// table memory read port. Allocate scans from index 1 for a free entry,
// find tail walks the chain, free walks it twice (check, then clear), read
// link reads one entry. After reset a clearing pass writes every entry;
// requests wait meanwhile, configuration writes are taken. A stalled result
// is held in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module fat_chain_manager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  fcm_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output fcm_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  fcm_pkg::cfg_reg_t             cfg_index,
  input  logic [fcm_pkg::CFG_W-1:0]     cfg_data
);

  logic [fcm_pkg::CODE_W-1:0] block_size_code;
  logic [fcm_pkg::CFG_W-1:0]  entry_count;
  logic [fcm_pkg::N_W-1:0]    n;
  logic [fcm_pkg::IDX_W-1:0]  rd_addr;
  logic [fcm_pkg::BLK_W-1:0]  rd_data;
  fcm_pkg::ram_wr_t           wr;
  fcm_pkg::fin_t              fin;
  logic                       fin_load;
  logic                       res_busy;

  assign cfg_ready = 1'b1;
  assign n         = fcm_pkg::eff_count(entry_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_code <= fcm_pkg::CODE_RESET;
      entry_count     <= fcm_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcm_pkg::CFG_BLOCK_SIZE:  block_size_code <= cfg_data[fcm_pkg::CODE_W-1:0];
        fcm_pkg::CFG_ENTRY_COUNT: entry_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  fcm_table_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .fin       (fin),
    .fin_load  (fin_load),
    .res_busy  (res_busy)
  );

  fcm_result u_result (
    .clk             (clk),
    .rst             (rst),
    .n               (n),
    .block_size_code (block_size_code),
    .fin             (fin),
    .fin_load        (fin_load),
    .res_busy        (res_busy),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp)
  );

endmodule

// ===== sv/fcm_checker.sv =====
// ----------------------------------------------------------------------------
// fcm_checker
// Port-level checks on the chain manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcm_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input fcm_pkg::rsp_t rsp
);

  // A request is worked alone, so the input is stalled after each transfer.
  `FCM_ASSERT_NXT(a_one_request, clk, rst, req_valid && !req_stall, req_stall, "request overlap")

  `FCM_ASSERT_NXT(a_rsp_held, clk, rst, rsp_valid && rsp_stall, rsp_valid, "result dropped")

  `FCM_ASSERT_NXT(a_rsp_stable, clk, rst, rsp_valid && rsp_stall, $stable(rsp), "result changed")

  // A failed request reports nothing but its status.
  `FCM_ASSERT_IMP(a_error_clean, clk, rst, rsp_valid && (rsp.status != fcm_pkg::ST_OK), (rsp.block_index == '0) && (rsp.freed_count == '0) && (rsp.data_offset == '0), "error result not clean")

endmodule

bind fat_chain_manager fcm_checker u_checker (.*);
